/* rtl/core/lfpu_pkg.sv */
// Shared widths, payload types and register codes for the leader-follow
// particle update core. No dependencies.
package lfpu_pkg;

  localparam int unsigned IDX_IN_W   = 7;
  localparam int unsigned POS_W      = 20;
  localparam int unsigned EXT_W      = 12;
  localparam int unsigned POS_FRAC   = POS_W - EXT_W;
  localparam int unsigned VEL_W      = 16;
  localparam int unsigned RAD_W      = 8;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [IDX_IN_W-1:0]       idx_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic signed [VEL_W-1:0]   vel_t;
  typedef logic [RAD_W-1:0]          rad_t;
  typedef logic [EXT_W-1:0]          ext_t;
  typedef logic [FRAC_W-1:0]         frac_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  localparam cfg_idx_t REG_ARENA_WIDTH    = 3'd0;
  localparam cfg_idx_t REG_ARENA_HEIGHT   = 3'd1;
  localparam cfg_idx_t REG_FOLLOW_GAIN    = 3'd2;
  localparam cfg_idx_t REG_DAMPING_FACTOR = 3'd3;
  localparam cfg_idx_t REG_LEADER_INDEX   = 3'd4;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  localparam vel_t VEL_MAX = 16'sh7FFF;
  localparam vel_t VEL_MIN = 16'sh8000;

  localparam ext_t  ARENA_RST  = 12'd1000;
  localparam frac_t GAIN_RST   = 16'd328;
  localparam frac_t DAMP_RST   = 16'd65470;
  localparam idx_t  LEADER_RST = 7'd0;

endpackage

/* rtl/core/lfpu_if.sv */
// Valid/ready channel interfaces for the particle command and result beats.
// Depends on lfpu_pkg.
interface lfpu_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  lfpu_pkg::idx_t       particle_index;
  lfpu_pkg::pos_t       load_pos_x;
  lfpu_pkg::pos_t       load_pos_y;
  lfpu_pkg::vel_t       load_vel_x;
  lfpu_pkg::vel_t       load_vel_y;
  lfpu_pkg::rad_t       load_radius;
  lfpu_pkg::frac_t      frame_time;

  modport source (
    output valid, mode, particle_index, load_pos_x, load_pos_y,
    output load_vel_x, load_vel_y, load_radius, frame_time,
    input  ready
  );
  modport sink (
    input  valid, mode, particle_index, load_pos_x, load_pos_y,
    input  load_vel_x, load_vel_y, load_radius, frame_time,
    output ready
  );
endinterface

interface lfpu_out_if;
  logic                 valid;
  logic                 ready;
  lfpu_pkg::idx_t       out_index;
  lfpu_pkg::pos_t       pos_x;
  lfpu_pkg::pos_t       pos_y;
  lfpu_pkg::vel_t       vel_x;
  lfpu_pkg::vel_t       vel_y;
  logic                 bounced_x;
  logic                 bounced_y;

  modport source (
    output valid, out_index, pos_x, pos_y, vel_x, vel_y, bounced_x, bounced_y,
    input  ready
  );
  modport sink (
    input  valid, out_index, pos_x, pos_y, vel_x, vel_y, bounced_x, bounced_y,
    output ready
  );
endinterface

/* rtl/core/leader_follow_particle_update_core.sv */
// Leader-follow particle table: particle memories and the update sequencer.
// Depends on lfpu_pkg and the channel interfaces in lfpu_if.
//
// Usage:
//   in_i carries command beats: mode 0 loads an entry, mode 1 moves one
//   entry toward the leader entry, damps its velocity and bounces it off
//   the arena walls. out_o returns one result beat per command with the
//   entry's new position, velocity and wall-hit flags.
//   cfg_we_i/cfg_index_i/cfg_wdata_i write the arena size, gain, damping
//   and leader index; write them only while no command is in flight.
//   One command is in flight at a time. A load goes from its accept straight
//   to the final step; an update steps through the synchronous memory read,
//   then two rounding multiplies (gain times distance, damping times
//   velocity) with their abs, round and saturate steps, then the writeback.
//   The result beat appears the cycle after the final step.
//   The result sits in an output register; a new command is accepted while
//   it waits. If the receiver stalls, the next command holds in its final
//   step until the output register frees up.
//   Reset clears the control state and restores the register defaults; the
//   particle memories are not cleared and must be loaded before update.
module leader_follow_particle_update_core #(
  parameter int unsigned MAX_PARTICLES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  lfpu_pkg::cfg_idx_t   cfg_index_i,
  input  lfpu_pkg::cfg_data_t  cfg_wdata_i,
  lfpu_in_if.sink              in_i,
  lfpu_out_if.source           out_o
);

  localparam int unsigned IDX_W    = $clog2(MAX_PARTICLES);
  localparam int unsigned IDX_SPAN = 1 << lfpu_pkg::IDX_IN_W;
  localparam int unsigned POS_W    = lfpu_pkg::POS_W;
  localparam int unsigned VEL_W    = lfpu_pkg::VEL_W;
  localparam int unsigned RAD_W    = lfpu_pkg::RAD_W;
  localparam int unsigned EXT_W    = lfpu_pkg::EXT_W;
  localparam int unsigned FRAC_W   = lfpu_pkg::FRAC_W;
  localparam int unsigned POS_FRAC = lfpu_pkg::POS_FRAC;
  localparam int unsigned P_W      = POS_W + 2;
  localparam int unsigned D_W      = POS_W + 3;
  localparam int unsigned M_W      = D_W - 1;
  localparam int unsigned GF_W     = 2 * FRAC_W;
  localparam int unsigned PR1_W    = M_W + GF_W;
  localparam int unsigned V_W      = D_W + 1;
  localparam int unsigned MV_W     = V_W - 1;
  localparam int unsigned PR2_W    = MV_W + FRAC_W;
  localparam int unsigned PM_W     = 2 * POS_W;
  localparam int unsigned VM_W     = 2 * VEL_W + RAD_W;

  localparam logic [MV_W-1:0] VEL_LIM = MV_W'(1) << (VEL_W - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_ABS  = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_ABSV = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_SAT  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  typedef logic [IDX_W-1:0] slot_t;
  typedef slot_t slot_tbl_t [IDX_SPAN];

  function automatic slot_tbl_t build_slot_tbl();
    slot_tbl_t tbl;
    for (int k = 0; k < IDX_SPAN; k++) begin
      tbl[k] = slot_t'(k % MAX_PARTICLES);
    end
    return tbl;
  endfunction

  localparam slot_tbl_t SLOT_TBL = build_slot_tbl();

  // configuration
  lfpu_pkg::ext_t  arena_w_q, arena_h_q;
  lfpu_pkg::frac_t gain_q, damp_q;
  lfpu_pkg::idx_t  leader_q;

  // control
  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire, done_fire;

  // memories and read registers
  logic [PM_W-1:0] pos_mem [MAX_PARTICLES];
  logic [VM_W-1:0] vr_mem  [MAX_PARTICLES];
  logic [PM_W-1:0] own_pos_q, lead_pos_q;
  logic [VM_W-1:0] vr_q;
  logic            mem_we;
  slot_t           mem_addr;
  logic [PM_W-1:0] pos_wdata;
  logic [VM_W-1:0] vr_wdata;

  // item registers
  logic            mode_q, self_q;
  slot_t           slot_q;
  slot_t           slot_in, slot_lead;
  logic [GF_W-1:0] gf_q;
  lfpu_pkg::pos_t  ld_pos_q [2];
  lfpu_pkg::vel_t  ld_vel_q [2];

  // per-axis datapath
  lfpu_pkg::ext_t         ext [2];
  lfpu_pkg::pos_t         own_pos [2];
  lfpu_pkg::pos_t         lead_pos [2];
  lfpu_pkg::vel_t         vel [2];
  lfpu_pkg::rad_t         rad;
  logic signed [P_W-1:0]  p_q [2], p_d [2];
  logic signed [D_W-1:0]  dx_q [2], dx_d [2];
  lfpu_pkg::pos_t         lo_q [2], lo_d [2];
  lfpu_pkg::pos_t         hi_q [2], hi_d [2];
  lfpu_pkg::pos_t         newpos_q [2], newpos_d [2];
  logic                   hit_q [2], hit_d [2];
  logic [M_W-1:0]         magdx_q [2], magdx_d [2];
  logic                   sdx_q [2], sdx_d [2];
  logic [PR1_W-1:0]       prod1_q [2], prod1_d [2];
  logic [M_W-1:0]         m1 [2];
  logic signed [V_W-1:0]  inc [2];
  logic signed [V_W-1:0]  v_q [2], v_d [2];
  logic [MV_W-1:0]        magv_q [2], magv_d [2];
  logic                   sv_q [2], sv_d [2];
  logic [PR2_W-1:0]       prod2_q [2], prod2_d [2];
  logic [MV_W-1:0]        m2 [2];
  lfpu_pkg::vel_t         nv_q [2], nv_d [2];
  lfpu_pkg::vel_t         vfin [2];
  logic                   hit_lo [2], hit_hi [2];
  logic signed [P_W-1:0]  lo_s [2], hi_s [2];

  // output register
  lfpu_pkg::idx_t out_idx_q;
  lfpu_pkg::pos_t out_pos_q [2];
  lfpu_pkg::vel_t out_vel_q [2];
  logic           out_hit_q [2];

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign done_fire  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign slot_in    = SLOT_TBL[in_i.particle_index];
  assign slot_lead  = SLOT_TBL[leader_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_w_q <= lfpu_pkg::ARENA_RST;
      arena_h_q <= lfpu_pkg::ARENA_RST;
      gain_q    <= lfpu_pkg::GAIN_RST;
      damp_q    <= lfpu_pkg::DAMP_RST;
      leader_q  <= lfpu_pkg::LEADER_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lfpu_pkg::REG_ARENA_WIDTH:    arena_w_q <= cfg_wdata_i[EXT_W-1:0];
        lfpu_pkg::REG_ARENA_HEIGHT:   arena_h_q <= cfg_wdata_i[EXT_W-1:0];
        lfpu_pkg::REG_FOLLOW_GAIN:    gain_q    <= cfg_wdata_i[FRAC_W-1:0];
        lfpu_pkg::REG_DAMPING_FACTOR: damp_q    <= cfg_wdata_i[FRAC_W-1:0];
        lfpu_pkg::REG_LEADER_INDEX:   leader_q  <= cfg_wdata_i[lfpu_pkg::IDX_IN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.mode == lfpu_pkg::MODE_UPDATE) ? S_READ : S_DONE;
        end
      end
      S_READ: state_d = S_ABS;
      S_ABS:  state_d = S_MUL1;
      S_MUL1: state_d = S_ACC;
      S_ACC:  state_d = S_ABSV;
      S_ABSV: state_d = S_MUL2;
      S_MUL2: state_d = S_SAT;
      S_SAT:  state_d = S_DONE;
      S_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = done_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-axis stage logic
  always_comb begin
    ext[0] = arena_w_q;
    ext[1] = arena_h_q;
    rad    = vr_q[2*VEL_W +: RAD_W];
    for (int a = 0; a < 2; a++) begin
      own_pos[a]  = own_pos_q[a*POS_W +: POS_W];
      lead_pos[a] = lead_pos_q[a*POS_W +: POS_W];
      vel[a]      = $signed(vr_q[a*VEL_W +: VEL_W]);

      p_d[a]  = $signed(P_W'(own_pos[a])) + P_W'(vel[a]);
      dx_d[a] = self_q ? '0 :
                $signed(D_W'(lead_pos[a])) - $signed(D_W'(own_pos[a])) - D_W'(vel[a]);
      lo_d[a] = POS_W'({rad, {POS_FRAC{1'b0}}});
      hi_d[a] = (ext[a] > EXT_W'(rad)) ?
                {ext[a] - EXT_W'(rad), {POS_FRAC{1'b0}}} : '0;

      lo_s[a]     = $signed(P_W'(lo_q[a]));
      hi_s[a]     = $signed(P_W'(hi_q[a]));
      hit_lo[a]   = p_q[a] < lo_s[a];
      hit_hi[a]   = p_q[a] > hi_s[a];
      hit_d[a]    = hit_lo[a] || hit_hi[a];
      newpos_d[a] = hit_lo[a] ? lo_q[a] : (hit_hi[a] ? hi_q[a] : p_q[a][POS_W-1:0]);
      sdx_d[a]    = dx_q[a][D_W-1];
      magdx_d[a]  = sdx_d[a] ? M_W'(-dx_q[a]) : M_W'(dx_q[a]);

      prod1_d[a] = PR1_W'(magdx_q[a]) * PR1_W'(gf_q);

      m1[a]  = M_W'(prod1_q[a][PR1_W-1:GF_W]) + M_W'(prod1_q[a][GF_W-1]);
      inc[a] = V_W'($signed({1'b0, m1[a]}));
      v_d[a] = V_W'(vel[a]) + (sdx_q[a] ? -inc[a] : inc[a]);

      sv_d[a]   = v_q[a][V_W-1];
      magv_d[a] = sv_d[a] ? MV_W'(-v_q[a]) : MV_W'(v_q[a]);

      prod2_d[a] = PR2_W'(magv_q[a]) * PR2_W'(damp_q);

      m2[a] = MV_W'(prod2_q[a][PR2_W-1:FRAC_W]) + MV_W'(prod2_q[a][FRAC_W-1]);
      if (sv_q[a]) begin
        nv_d[a] = (m2[a] > VEL_LIM) ? lfpu_pkg::VEL_MIN :
                  $signed(VEL_W'(MV_W'(0) - m2[a]));
      end else begin
        nv_d[a] = (m2[a] > VEL_LIM - MV_W'(1)) ? lfpu_pkg::VEL_MAX :
                  $signed(VEL_W'(m2[a]));
      end

      if (hit_q[a]) begin
        vfin[a] = (nv_q[a] == lfpu_pkg::VEL_MIN) ? lfpu_pkg::VEL_MAX : -nv_q[a];
      end else begin
        vfin[a] = nv_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q      <= in_i.mode;
      slot_q      <= slot_in;
      self_q      <= (slot_in == slot_lead);
      gf_q        <= GF_W'(gain_q) * GF_W'(in_i.frame_time);
      ld_pos_q[0] <= in_i.load_pos_x;
      ld_pos_q[1] <= in_i.load_pos_y;
      ld_vel_q[0] <= in_i.load_vel_x;
      ld_vel_q[1] <= in_i.load_vel_y;
    end
    for (int a = 0; a < 2; a++) begin
      if (state_q == S_READ) begin
        p_q[a]  <= p_d[a];
        dx_q[a] <= dx_d[a];
        lo_q[a] <= lo_d[a];
        hi_q[a] <= hi_d[a];
      end
      if (state_q == S_ABS) begin
        newpos_q[a] <= newpos_d[a];
        hit_q[a]    <= hit_d[a];
        sdx_q[a]    <= sdx_d[a];
        magdx_q[a]  <= magdx_d[a];
      end
      if (state_q == S_MUL1) begin
        prod1_q[a] <= prod1_d[a];
      end
      if (state_q == S_ACC) begin
        v_q[a] <= v_d[a];
      end
      if (state_q == S_ABSV) begin
        sv_q[a]   <= sv_d[a];
        magv_q[a] <= magv_d[a];
      end
      if (state_q == S_MUL2) begin
        prod2_q[a] <= prod2_d[a];
      end
      if (state_q == S_SAT) begin
        nv_q[a] <= nv_d[a];
      end
    end
  end

  // loads write at accept, updates write back on leaving the final step
  always_comb begin
    if (in_fire) begin
      mem_we    = (in_i.mode == lfpu_pkg::MODE_LOAD);
      mem_addr  = slot_in;
      pos_wdata = {in_i.load_pos_y, in_i.load_pos_x};
      vr_wdata  = {in_i.load_radius, in_i.load_vel_y, in_i.load_vel_x};
    end else begin
      mem_we    = done_fire && (mode_q == lfpu_pkg::MODE_UPDATE);
      mem_addr  = slot_q;
      pos_wdata = {newpos_q[1], newpos_q[0]};
      vr_wdata  = {rad, vfin[1], vfin[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pos_mem[mem_addr] <= pos_wdata;
      vr_mem[mem_addr]  <= vr_wdata;
    end
    if (in_fire) begin
      own_pos_q  <= pos_mem[slot_in];
      lead_pos_q <= pos_mem[slot_lead];
      vr_q       <= vr_mem[slot_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_idx_q <= lfpu_pkg::IDX_IN_W'(slot_q);
      for (int a = 0; a < 2; a++) begin
        if (mode_q == lfpu_pkg::MODE_UPDATE) begin
          out_pos_q[a] <= newpos_q[a];
          out_vel_q[a] <= vfin[a];
          out_hit_q[a] <= hit_q[a];
        end else begin
          out_pos_q[a] <= ld_pos_q[a];
          out_vel_q[a] <= ld_vel_q[a];
          out_hit_q[a] <= 1'b0;
        end
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_index = out_idx_q;
  assign out_o.pos_x     = out_pos_q[0];
  assign out_o.pos_y     = out_pos_q[1];
  assign out_o.vel_x     = out_vel_q[0];
  assign out_o.vel_y     = out_vel_q[1];
  assign out_o.bounced_x = out_hit_q[0];
  assign out_o.bounced_y = out_hit_q[1];

endmodule

/* rtl/core/lfpu_checker.sv */
// Port-level checks for the leader-follow particle update core, bound to
// the top level. Depends on lfpu_pkg and leader_follow_particle_update_core.
module lfpu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input lfpu_pkg::idx_t out_index_i,
  input lfpu_pkg::pos_t out_pos_x_i,
  input lfpu_pkg::vel_t out_vel_x_i,
  input lfpu_pkg::vel_t out_vel_y_i,
  input logic           out_bounced_x_i,
  input logic           out_bounced_y_i
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_index_i) && $stable(out_pos_x_i) &&
      $stable(out_vel_x_i) && $stable(out_vel_y_i))
    else $error("result beat changed while stalled");

  // one command in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second command accepted while one is in flight");

  // a result only follows a command in flight
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result beat without a command in flight");

  // a bounce negates with saturation, so the most negative code never shows
  a_bounce_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      !(out_bounced_x_i && out_vel_x_i == lfpu_pkg::VEL_MIN) &&
      !(out_bounced_y_i && out_vel_y_i == lfpu_pkg::VEL_MIN))
    else $error("bounced velocity at most negative code");

endmodule

bind leader_follow_particle_update_core lfpu_checker u_lfpu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_index_i     (out_o.out_index),
  .out_pos_x_i     (out_o.pos_x),
  .out_vel_x_i     (out_o.vel_x),
  .out_vel_y_i     (out_o.vel_y),
  .out_bounced_x_i (out_o.bounced_x),
  .out_bounced_y_i (out_o.bounced_y)
);
